// File: hdl/qstk_pkg.sv
// Shared widths, register indexes and divider handshake types for the
// candle body moving average block. No dependencies.
`timescale 1ns / 1ps

package qstk_pkg;

	localparam int MAX_WINDOW = 256;
	localparam int RING_AW    = $clog2(MAX_WINDOW);
	localparam int WIN_W      = $clog2(MAX_WINDOW + 1);

	localparam int PRICE_W = 32;
	localparam int BODY_W  = PRICE_W + 1;
	localparam int SUM_W   = BODY_W + RING_AW;
	localparam int AVG_W   = 33;
	localparam int IDX_W   = 32;

	localparam int CFG_AW  = 2;
	localparam int CFG_DW  = 32;
	localparam int WLEN_W  = 9;

	localparam logic [CFG_AW-1:0] REG_WINDOW_LENGTH = CFG_AW'(0);
	localparam logic [CFG_AW-1:0] REG_START_INDEX   = CFG_AW'(1);

	localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(14);

	localparam logic signed [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
	localparam logic signed [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

	localparam int DIV_CNT_W = $clog2(SUM_W + 1);

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [WIN_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// File: hdl/qstk_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module qstk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/qstk_div.sv
// Serial signed divider: window sum by window length, one quotient bit per cycle,
// truncation toward zero and saturation to the result width. Uses qstk_pkg.
`timescale 1ns / 1ps

module qstk_div
	import qstk_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  div_req_t                req,
	output div_sts_t                sts,
	output logic signed [AVG_W-1:0] quotient
);

	logic [DIV_CNT_W-1:0] count_q;
	logic                 done_q;
	logic                 neg_q;
	logic [WIN_W-1:0]     divisor_q;
	logic [WIN_W-2:0]     rem_q;
	logic [SUM_W-1:0]     quo_q;

	logic [WIN_W-1:0]     trial;
	logic                 fits;
	logic [SUM_W-1:0]     mag;
	logic                 too_big;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= divisor_q;
	assign mag   = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				count_q <= DIV_CNT_W'(SUM_W);
			end else if (count_q != '0) begin
				count_q <= count_q - 1'b1;
				if (count_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q     <= req.dividend[SUM_W-1];
			divisor_q <= req.divisor;
			rem_q     <= '0;
			quo_q     <= mag;
		end else if (count_q != '0) begin
			// shift in one dividend bit, subtract when the divisor fits
			rem_q <= fits ? (WIN_W-1)'(trial - divisor_q) : trial[WIN_W-2:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign too_big = |quo_q[SUM_W-1:AVG_W-1];

	always_comb begin
		if (neg_q) begin
			quotient = too_big ? AVG_MIN : AVG_W'(~quo_q[AVG_W-1:0] + 1'b1);
		end else begin
			quotient = too_big ? AVG_MAX : AVG_W'(quo_q[AVG_W-1:0]);
		end
	end

	assign sts.busy = count_q != '0;
	assign sts.done = done_q;

endmodule

// File: hdl/candle_body_moving_average.sv
// Candle body moving average (Qstick) top level: config registers, ring
// bookkeeping, sequencer and output register. Uses qstk_pkg, qstk_ram, qstk_div.
`timescale 1ns / 1ps

// Usage
//   Input channel: open_price, close_price, last_bar with in_valid / in_stall.
//   Output channel: average_body, bar_index, last_result with out_valid /
//   out_stall. Config channel: cfg_valid / cfg_ready (always ready),
//   cfg_index 0 = window_length, 1 = start_index, other indexes ignored.
//   Change config only while the block is idle.
//   Sequence: an accepted bar writes its body into the 256-entry ring RAM and
//   reads the trailing body in the same cycle; in the following cycle the sum
//   is updated. A bar with no result then returns to idle. A bar with a result
//   runs the serial divider, which shifts through every sum bit; out_valid
//   rises when the quotient is loaded into the output register, and the next
//   bar can enter from then on.
//   The output register holds a finished result while the receiver stalls;
//   the next bar is still taken, and only its own result waits for the slot.
//   Reset: sum, slot and bar counter clear, window_length = 14,
//   start_index = 0. The ring needs no clearing pass: entries are read only
//   after the current series has written them.
module candle_body_moving_average
	import qstk_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [PRICE_W-1:0] open_price,
	input  logic signed [PRICE_W-1:0] close_price,
	input  logic                      last_bar,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [AVG_W-1:0]   average_body,
	output logic [IDX_W-1:0]          bar_index,
	output logic                      last_result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_AW-1:0]         cfg_index,
	input  logic [CFG_DW-1:0]         cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_DIV,
		ST_WAIT
	} state_t;

	state_t state_q;

	logic [WLEN_W-1:0]       window_length_q;
	logic [IDX_W-1:0]        start_index_q;
	logic signed [SUM_W-1:0] window_sum_q;
	logic [RING_AW-1:0]      slot_q;
	logic [IDX_W-1:0]        bars_seen_q;

	logic signed [BODY_W-1:0] body_s1;
	logic signed [SUM_W-1:0]  sum_plus_s1;
	logic                     fwd_s1;
	logic                     drop_s1;
	logic                     emit_s1;
	logic                     last_s1;
	logic [IDX_W-1:0]         index_s1;

	logic                     accept;
	logic                     out_free;
	logic                     out_load;
	logic [WIN_W-1:0]         win;
	logic [WIN_W-1:0]         win_m1;
	logic signed [BODY_W-1:0] body;
	logic [RING_AW-1:0]       trail;
	logic                     drop;
	logic [BODY_W-1:0]        ring_rdata;
	logic signed [BODY_W-1:0] trail_body;

	div_req_t                 div_req;
	div_sts_t                 div_sts;
	logic signed [AVG_W-1:0]  div_quotient;

	assign cfg_ready = 1'b1;
	assign in_stall  = state_q != ST_IDLE;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign out_load  = ((state_q == ST_DIV && div_sts.done) || state_q == ST_WAIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WLEN_RESET;
			start_index_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_LENGTH: window_length_q <= cfg_data[WLEN_W-1:0];
				REG_START_INDEX:   start_index_q   <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (window_length_q == '0) begin
			win = WIN_W'(1);
		end else if (32'(window_length_q) > 32'(MAX_WINDOW)) begin
			win = WIN_W'(MAX_WINDOW);
		end else begin
			win = WIN_W'(window_length_q);
		end
	end

	assign win_m1 = win - 1'b1;
	assign body   = BODY_W'(close_price) - BODY_W'(open_price);
	assign trail  = slot_q - win_m1[RING_AW-1:0];
	assign drop   = bars_seen_q >= IDX_W'(win_m1);

	qstk_ram #(
		.WIDTH(BODY_W),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (accept),
		.waddr(slot_q),
		.wdata(body),
		.raddr(trail),
		.rdata(ring_rdata)
	);

	// a one-bar window reads the slot being written: take the new body
	assign trail_body = fwd_s1 ? body_s1 : $signed(ring_rdata);

	always_ff @(posedge clk) begin
		if (accept) begin
			body_s1     <= body;
			sum_plus_s1 <= window_sum_q + SUM_W'(body);
			fwd_s1      <= trail == slot_q;
			drop_s1     <= drop;
			emit_s1     <= drop && (bars_seen_q >= start_index_q);
			last_s1     <= last_bar;
			index_s1    <= bars_seen_q;
		end
	end

	assign div_req.start    = (state_q == ST_RD) && emit_s1;
	assign div_req.dividend = sum_plus_s1;
	assign div_req.divisor  = win;

	qstk_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.sts     (div_sts),
		.quotient(div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			window_sum_q <= '0;
			slot_q       <= '0;
			bars_seen_q  <= '0;
			out_valid    <= 1'b0;
			average_body <= '0;
			bar_index    <= '0;
			last_result  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid    <= 1'b1;
				average_body <= div_quotient;
				bar_index    <= index_s1;
				last_result  <= last_s1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD;
						if (last_bar) begin
							slot_q      <= '0;
							bars_seen_q <= '0;
						end else begin
							slot_q <= slot_q + 1'b1;
							if (bars_seen_q != '1) begin
								bars_seen_q <= bars_seen_q + 1'b1;
							end
						end
					end
				end
				ST_RD: begin
					if (last_s1) begin
						window_sum_q <= '0;
					end else if (drop_s1) begin
						window_sum_q <= sum_plus_s1 - SUM_W'(trail_body);
					end else begin
						window_sum_q <= sum_plus_s1;
					end
					state_q <= emit_s1 ? ST_DIV : ST_IDLE;
				end
				ST_DIV, ST_WAIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end else if (div_sts.done || state_q == ST_WAIT) begin
						// hold the quotient in the divider until the slot frees
						state_q <= ST_WAIT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_accept_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_sts.busy)
		else $error("item accepted while divider busy");

	a_accept_to_rd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RD)
		else $error("accepted item did not advance to ring read");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

	a_start_from_rd: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> state_q == ST_DIV && div_sts.busy)
		else $error("divider start without divide state");

endmodule
